>>> rtl/thermistor_window_average_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor window average core
// Clocked on clk_i and muted while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define THERMISTOR_WINDOW_AVERAGE_CORE_DEFINES_SVH

// Check that an expression holds at every edge.
`define TWA_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence at the same edge.
`define TWA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// twa_pkg
// Types, widths and fixed-point constants of the thermistor window average.
// ----------------------------------------------------------------------------
package twa_pkg;

  localparam int WINDOW_LENGTH_DEF = 10;
  localparam int ADC_BITS_DEF      = 12;

  localparam int BETA_W = 14;
  localparam logic [BETA_W-1:0] BETA_RESET = 14'd3950;

  localparam int TEMP_W = 16;

  localparam int NUM_W = 57;
  localparam int DEN_W = 48;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam int LOG_IN_W = 31;
  localparam int FRAC_W   = 24;
  localparam int EXP_W    = 5;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int LN2_W    = 30;
  localparam int PROD_W   = LOG_W + LN2_W;
  localparam int SQ_W     = 2 * LOG_IN_W;

  localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
  localparam logic [DEN_W-1:0] INV_T0_Q40 =
    DEN_W'(((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815);
  localparam int TQ_W = 26;
  localparam logic [TQ_W-1:0] KELVIN_Q16 = TQ_W'((64'd27315 * 64'd65536 + 64'd50) / 64'd100);
  localparam logic [TQ_W-1:0] TLO_Q = KELVIN_Q16 - TQ_W'(40 * 65536);
  localparam logic [TQ_W-1:0] THI_Q = KELVIN_Q16 + TQ_W'(125 * 65536);
  localparam logic [NUM_W-1:0] DIV_ONE_Q56 = NUM_W'(1) << 56;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_Q8  = -16'sd10240;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_Q8 = 16'sd32000;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [LOG_IN_W-1:0] x;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] res;
  } log_rsp_t;

endpackage

>>> rtl/twa_in_if.sv
// ----------------------------------------------------------------------------
// twa_in_if
// Scan channel: two ADC codes per item.
// ----------------------------------------------------------------------------
interface twa_in_if import twa_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] temperature_code;
  logic [ADC_BITS-1:0] ethanol_code;

  modport source (output valid, temperature_code, ethanol_code, input ready);
  modport sink   (input valid, temperature_code, ethanol_code, output ready);
endinterface

>>> rtl/twa_out_if.sv
// ----------------------------------------------------------------------------
// twa_out_if
// Result channel: temperature, ethanol ratio and range flag.
// ----------------------------------------------------------------------------
interface twa_out_if import twa_pkg::*; #(
  parameter int RATIO_W = ADC_BITS_DEF + 16
);
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q8;
  logic [RATIO_W-1:0]       ethanol_ratio_q16;
  logic                     out_of_range;

  modport source (output valid, temperature_q8, ethanol_ratio_q16, out_of_range, input ready);
  modport sink   (input valid, temperature_q8, ethanol_ratio_q16, out_of_range, output ready);
endinterface

>>> rtl/twa_cfg_if.sv
// ----------------------------------------------------------------------------
// twa_cfg_if
// Configuration write channel for the beta register.
// ----------------------------------------------------------------------------
interface twa_cfg_if import twa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BETA_W-1:0] beta_coefficient;

  modport source (output valid, beta_coefficient, input ready);
  modport sink   (input valid, beta_coefficient, output ready);
endinterface

>>> rtl/twa_ram.sv
// ----------------------------------------------------------------------------
// twa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/twa_div.sv
// ----------------------------------------------------------------------------
// twa_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twa_div import twa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule

>>> rtl/twa_log.sv
// ----------------------------------------------------------------------------
// twa_log
// Base-2 logarithm in Q24: leading-one search, then 24 squaring steps.
// ----------------------------------------------------------------------------
module twa_log import twa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  log_req_t req_i,
  output log_rsp_t rsp_o
);
  typedef enum logic [1:0] {L_IDLE, L_NORM, L_MUL, L_ADJ} lstate_e;

  lstate_e              state_q;
  logic                 done_q;
  logic [EXP_W-1:0]     exp_q;
  logic [FRAC_W-1:0]    frac_q;
  logic [4:0]           cnt_q;
  logic [LOG_IN_W-1:0]  m_q;
  logic [SQ_W-1:0]      sq_q;
  logic [LOG_IN_W:0]    top;

  assign top = sq_q[SQ_W-1:LOG_IN_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (m_q[LOG_IN_W-1]) begin
            state_q <= L_MUL;
            cnt_q   <= 5'(FRAC_W);
          end
        end
        L_MUL: begin
          state_q <= L_ADJ;
        end
        L_ADJ: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            state_q <= L_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= L_MUL;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          m_q   <= req_i.x;
          exp_q <= EXP_W'(LOG_IN_W - 1);
        end
      end
      L_NORM: begin
        if (!m_q[LOG_IN_W-1]) begin
          m_q   <= {m_q[LOG_IN_W-2:0], 1'b0};
          exp_q <= exp_q - EXP_W'(1);
        end
      end
      L_MUL: begin
        sq_q <= SQ_W'(m_q) * SQ_W'(m_q);
      end
      L_ADJ: begin
        m_q    <= top[LOG_IN_W] ? top[LOG_IN_W:1] : top[LOG_IN_W-1:0];
        frac_q <= {frac_q[FRAC_W-2:0], top[LOG_IN_W]};
      end
      default: begin
        m_q <= m_q;
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = {exp_q, frac_q};
endmodule

>>> rtl/thermistor_window_average_core.sv
// ----------------------------------------------------------------------------
// thermistor_window_average_core
// Keeps a sliding window of the last WINDOW_LENGTH scans per channel and, once
// the window is full, returns per scan the NTC beta-equation temperature (Q8.8
// degC), the ethanol ratio (Q16) and a range flag. A scan with a result makes up
// to three passes through the shared divider and up to two log2 runs (each a
// leading-one search plus 24 squarings). The scan port is ready only while the
// sequencer is idle. A finished result waits in an output register, so the
// next scan may be taken before it is collected.
// ----------------------------------------------------------------------------
`include "thermistor_window_average_core_defines.svh"

module thermistor_window_average_core import twa_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int ADC_BITS      = ADC_BITS_DEF,
  localparam int RATIO_W = ADC_BITS + 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  twa_in_if.sink       in_i,
  twa_out_if.source    out_o,
  twa_cfg_if.sink      cfg_i
);
  localparam int SUM_W  = ADC_BITS + $clog2(WINDOW_LENGTH + 1);
  localparam int AW     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
  localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(ADC_MAX) * SUM_W'(WINDOW_LENGTH);
  localparam logic [RATIO_W-1:0] RATIO_MAX = {ADC_MAX - ADC_BITS'(1), 16'h0};

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_RAT, S_RAT_W, S_LOGA, S_LOGA_W, S_LOGB, S_LOGB_W,
    S_MUL, S_LDIV, S_LDIV_W, S_INV, S_TDIV, S_TDIV_W, S_DONE
  } state_e;

  state_e                   state_q;
  logic [BETA_W-1:0]        beta_q;
  logic [SUM_W-1:0]         st_q, se_q, st_d, se_d;
  logic [AW-1:0]            slot_q;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [ADC_BITS-1:0]      tc_q, ec_q, old_t, old_e;
  logic [2*ADC_BITS-1:0]    rdata;
  logic [LOG_W-1:0]         la_q, dmag_q;
  logic                     dneg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DEN_W-1:0]         inv_q;
  logic [DEN_W+1:0]         inv_s;
  logic                     sat_q;
  logic [RATIO_W-1:0]       ratio_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [RATIO_W-1:0]       out_ratio_q;
  logic                     out_oor_q;
  logic [TQ_W-1:0]          tq;
  logic [BETA_W-1:0]        beta_eff;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  log_req_t                 log_req;
  log_rsp_t                 log_rsp;

  twa_ram #(.WIDTH(2 * ADC_BITS), .DEPTH(WINDOW_LENGTH)) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPD),
    .waddr_i (slot_q),
    .wdata_i ({tc_q, ec_q}),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  twa_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  twa_log u_log (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(log_req), .rsp_o(log_rsp));

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign beta_eff    = (beta_q == '0) ? BETA_W'(1) : beta_q;

  always_comb begin
    old_t  = (fill_q < FILL_W'(WINDOW_LENGTH)) ? '0 : rdata[2*ADC_BITS-1:ADC_BITS];
    old_e  = (fill_q < FILL_W'(WINDOW_LENGTH)) ? '0 : rdata[ADC_BITS-1:0];
    st_d   = st_q - SUM_W'(old_t) + SUM_W'(tc_q);
    se_d   = se_q - SUM_W'(old_e) + SUM_W'(ec_q);
    fill_d = (fill_q < FILL_W'(WINDOW_LENGTH)) ? fill_q + FILL_W'(1) : fill_q;
  end

  always_comb begin
    div_req.start = (state_q == S_RAT) || (state_q == S_LDIV) || (state_q == S_TDIV);
    case (state_q)
      S_RAT: begin
        div_req.num = NUM_W'(FULL_SUM - se_q) << 16;
        div_req.den = DEN_W'(se_q);
      end
      S_LDIV: begin
        div_req.num = NUM_W'(prod_q[PROD_W-1:LN2_W]) << 16;
        div_req.den = DEN_W'(beta_eff);
      end
      default: begin
        div_req.num = DIV_ONE_Q56;
        div_req.den = inv_q;
      end
    endcase
    log_req.start = (state_q == S_LOGA) || (state_q == S_LOGB);
    log_req.x     = (state_q == S_LOGA) ? LOG_IN_W'(st_q) : LOG_IN_W'(FULL_SUM - st_q);
  end

  assign inv_s = dneg_q ? (DEN_W+2)'(INV_T0_Q40) - (DEN_W+2)'(div_rsp.quot)
                        : (DEN_W+2)'(INV_T0_Q40) + (DEN_W+2)'(div_rsp.quot);
  assign tq    = div_rsp.quot[TQ_W-1:0] - TLO_Q + TQ_W'(128);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      beta_q      <= BETA_RESET;
      st_q        <= '0;
      se_q        <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        beta_q <= cfg_i.beta_coefficient;
      end
      if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          st_q   <= st_d;
          se_q   <= se_d;
          fill_q <= fill_d;
          slot_q <= (slot_q == AW'(WINDOW_LENGTH - 1)) ? '0 : slot_q + AW'(1);
          state_q <= (fill_d == FILL_W'(WINDOW_LENGTH)) ? S_RAT : S_IDLE;
        end
        S_RAT: begin
          state_q <= S_RAT_W;
        end
        S_RAT_W: begin
          if (div_rsp.done) begin
            state_q <= ((st_q == '0) || (st_q >= FULL_SUM)) ? S_DONE : S_LOGA;
          end
        end
        S_LOGA: begin
          state_q <= S_LOGA_W;
        end
        S_LOGA_W: begin
          if (log_rsp.done) begin
            state_q <= S_LOGB;
          end
        end
        S_LOGB: begin
          state_q <= S_LOGB_W;
        end
        S_LOGB_W: begin
          if (log_rsp.done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_LDIV;
        end
        S_LDIV: begin
          state_q <= S_LDIV_W;
        end
        S_LDIV_W: begin
          if (div_rsp.done) begin
            state_q <= S_INV;
          end
        end
        S_INV: begin
          state_q <= (inv_s[DEN_W+1] || (inv_s == '0)) ? S_DONE : S_TDIV;
        end
        S_TDIV: begin
          state_q <= S_TDIV_W;
        end
        S_TDIV_W: begin
          if (div_rsp.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        tc_q <= in_i.temperature_code;
        ec_q <= in_i.ethanol_code;
      end
      S_RAT: begin
        sat_q  <= (se_q == '0) || (se_q >= FULL_SUM) || (st_q == '0) || (st_q >= FULL_SUM);
        temp_q <= TEMP_LOW_Q8;
      end
      S_RAT_W: begin
        if (se_q == '0) begin
          ratio_q <= RATIO_MAX;
        end else if (se_q >= FULL_SUM) begin
          ratio_q <= '0;
        end else if (div_rsp.quot > NUM_W'(RATIO_MAX)) begin
          ratio_q <= RATIO_MAX;
        end else begin
          ratio_q <= div_rsp.quot[RATIO_W-1:0];
        end
      end
      S_LOGA_W: begin
        la_q <= log_rsp.res;
      end
      S_LOGB_W: begin
        dneg_q <= la_q < log_rsp.res;
        dmag_q <= (la_q < log_rsp.res) ? log_rsp.res - la_q : la_q - log_rsp.res;
      end
      S_MUL: begin
        prod_q <= PROD_W'(dmag_q) * PROD_W'(LN2_Q30);
      end
      S_INV: begin
        inv_q <= inv_s[DEN_W-1:0];
        if (inv_s[DEN_W+1]) begin
          sat_q <= 1'b1;
        end else if (inv_s == '0) begin
          sat_q  <= 1'b1;
          temp_q <= TEMP_HIGH_Q8;
        end
      end
      S_TDIV_W: begin
        if (div_rsp.done) begin
          if (div_rsp.quot < NUM_W'(TLO_Q)) begin
            sat_q <= 1'b1;
          end else if (div_rsp.quot > NUM_W'(THI_Q)) begin
            sat_q  <= 1'b1;
            temp_q <= TEMP_HIGH_Q8;
          end else begin
            temp_q <= TEMP_W'(tq >> 8) + TEMP_LOW_Q8;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_temp_q  <= temp_q;
          out_ratio_q <= ratio_q;
          out_oor_q   <= sat_q;
        end
      end
      default: begin
        la_q <= la_q;
      end
    endcase
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.temperature_q8    = out_temp_q;
  assign out_o.ethanol_ratio_q16 = out_ratio_q;
  assign out_o.out_of_range      = out_oor_q;

  `TWA_ASSERT(a_fill_bound, fill_q <= FILL_W'(WINDOW_LENGTH), "fill count overran window")
  `TWA_ASSERT(a_sum_bound, (st_q <= FULL_SUM) && (se_q <= FULL_SUM), "window sum overran")
  `TWA_ASSERT_IMPL(a_fill_before_math, state_q == S_RAT, fill_q == FILL_W'(WINDOW_LENGTH), "result before window full")
  `TWA_ASSERT_IMPL(a_temp_range, out_valid_q, (out_temp_q >= TEMP_LOW_Q8) && (out_temp_q <= TEMP_HIGH_Q8), "temperature outside limits")
endmodule

>>> dv/twa_window_checker.sv
// ----------------------------------------------------------------------------
// Scan window checker
// Watches the scan, result and beta channels, keeps its own copy of both
// sample windows and the beta register, predicts the temperature, ethanol ratio
// and range flag of every full-window scan and compares them with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twa_window_checker import twa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  twa_in_if    in_m,
  twa_out_if   out_m,
  twa_cfg_if   cfg_m,
  output int   errors_o,
  output int   pending_o
);
  localparam int NWIN = 10;
  localparam longint FULL = 4095 * NWIN;
  localparam longint LN2 = 744261118;
  localparam longint INV_T0 = ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;
  localparam longint KELV = (64'd27315 * 64'd65536 + 64'd50) / 64'd100;
  localparam longint RATIO_TOP = 64'd4094 << 16;

  typedef struct {
    logic signed [15:0] temp_q8;
    logic [27:0]        ratio_q16;
    logic               flag;
  } reading_t;

  reading_t   readings_q[$];
  logic [11:0] temp_win[NWIN];
  logic [11:0] eth_win[NWIN];
  longint     temp_sum, eth_sum;
  int         slot, filled;
  logic [13:0] beta;

  function automatic longint log2_fix(longint x);
    int     e;
    longint m, frac;
    e = 0;
    frac = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 24) | frac;
  endfunction

  function automatic longint temp_of(longint s, logic [13:0] b, inout logic sat);
    longint d, l, inv, t, bb;
    if (s == 0 || s >= FULL) begin
      sat = 1'b1;
      return -10240;
    end
    d = log2_fix(s) - log2_fix(FULL - s);
    l = (d * LN2) / (64'sd1 <<< 30);
    bb = (b == 0) ? 1 : longint'(b);
    inv = (l * 65536) / bb + INV_T0;
    if (inv < 0) begin
      sat = 1'b1;
      return -10240;
    end
    if (inv == 0) begin
      sat = 1'b1;
      return 32000;
    end
    t = longint'((64'd1 << 56) / inv) - KELV;
    if (t < -(64'sd40 <<< 16)) begin
      sat = 1'b1;
      return -10240;
    end
    if (t > (64'sd125 <<< 16)) begin
      sat = 1'b1;
      return 32000;
    end
    return ((t + (64'sd40 <<< 16) + 128) >>> 8) - 10240;
  endfunction

  function automatic longint ratio_of(longint s, inout logic sat);
    longint q;
    if (s == 0) begin
      sat = 1'b1;
      return RATIO_TOP;
    end
    if (s >= FULL) begin
      sat = 1'b1;
      return 0;
    end
    q = ((FULL - s) << 16) / s;
    return (q > RATIO_TOP) ? RATIO_TOP : q;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t r, want;
    logic     sat;
    int       errs;
    if (!rst_ni) begin
      for (int i = 0; i < NWIN; i++) begin
        temp_win[i] = '0;
        eth_win[i] = '0;
      end
      temp_sum = 0;
      eth_sum = 0;
      slot = 0;
      filled = 0;
      beta = BETA_RESET;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      errs = errors_o;
      if (cfg_m.valid && cfg_m.ready) beta = cfg_m.beta_coefficient;
      if (out_m.valid && out_m.ready) begin
        if (readings_q.size() == 0) begin
          $error("unexpected result temp=%0d ratio=%0d flag=%0b", out_m.temperature_q8,
                 out_m.ethanol_ratio_q16, out_m.out_of_range);
          errs++;
        end else begin
          want = readings_q.pop_front();
          if (out_m.temperature_q8 !== want.temp_q8) begin
            $error("temperature_q8 expected %0d actual %0d", want.temp_q8,
                   out_m.temperature_q8);
            errs++;
          end
          if (out_m.ethanol_ratio_q16 !== want.ratio_q16) begin
            $error("ethanol_ratio_q16 expected %0d actual %0d", want.ratio_q16,
                   out_m.ethanol_ratio_q16);
            errs++;
          end
          if (out_m.out_of_range !== want.flag) begin
            $error("out_of_range expected %0b actual %0b", want.flag, out_m.out_of_range);
            errs++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        temp_sum = temp_sum - temp_win[slot] + in_m.temperature_code;
        eth_sum = eth_sum - eth_win[slot] + in_m.ethanol_code;
        temp_win[slot] = in_m.temperature_code;
        eth_win[slot] = in_m.ethanol_code;
        slot = (slot + 1 >= NWIN) ? 0 : slot + 1;
        if (filled < NWIN) filled++;
        if (filled >= NWIN) begin
          sat = 1'b0;
          r.temp_q8 = 16'(temp_of(temp_sum, beta, sat));
          r.ratio_q16 = 28'(ratio_of(eth_sum, sat));
          r.flag = sat;
          readings_q.push_back(r);
        end
      end
      errors_o <= errs;
      pending_o <= readings_q.size();
    end
  end
endmodule

>>> dv/tb_thermistor_window_average_core.sv
// ----------------------------------------------------------------------------
// Thermistor window average testbench
// Drives directed and random ADC scans with random idling on both sides,
// rewrites the beta register between phases and leaves checking to the
// scan window checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_thermistor_window_average_core;
  import twa_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   cycles = 0;
  logic quiet = 1'b0;
  int   temp_base, eth_base;

  twa_in_if  in_if();
  twa_out_if out_if();
  twa_cfg_if cfg_if();

  thermistor_window_average_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  twa_window_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_m     (in_if),
    .out_m    (out_if),
    .cfg_m    (cfg_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  end

  task automatic send(logic [11:0] tc, logic [11:0] ec);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.temperature_code <= tc;
    in_if.ethanol_code <= ec;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_beta(logic [13:0] b);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.beta_coefficient <= b;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [11:0] jitter(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
  endfunction

  task automatic random_scans(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) begin
        temp_base = $urandom_range(0, 4095);
        eth_base = $urandom_range(0, 4095);
      end
      if (mode == 0) send($urandom_range(0, 4095), $urandom_range(0, 4095));
      else if (mode == 1) send($urandom_range(0, 1) ? 12'd4095 : 12'd0,
                               $urandom_range(0, 1) ? 12'd4095 : 12'd0);
      else send(jitter(temp_base, 40), jitter(eth_base, 40));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.temperature_code = '0;
    in_if.ethanol_code = '0;
    cfg_if.valid = 1'b0;
    cfg_if.beta_coefficient = '0;
    temp_base = 2048;
    eth_base = 1500;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 10; i++) send(12'd0, 12'd0);
    for (int i = 0; i < 10; i++) send(12'd4095, 12'd4095);
    send(12'd1, 12'd4094);
    send(12'd2048, 12'd1);
    send(12'hAAA, 12'h555);
    send(12'h555, 12'hAAA);

    write_beta(14'd1000);
    random_scans(350);
    drain();
    random_scans(50);
    write_beta(14'd10000);
    random_scans(400);
    write_beta(14'd0);
    random_scans(300);
    write_beta(14'h3FFF);
    random_scans(300);
    write_beta(14'($urandom_range(1000, 10000)));
    random_scans(300);
    quiet = 1'b1;
    random_scans(226);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
